/* rtl/sts_pkg.sv */
// Shared types and constants for the s-expression token scanner.
// Used by sts_front, sts_queue, sts_back and the top level; depends on nothing.
package sts_pkg;

    typedef enum logic [3:0] {
        CLS_INT    = 4'd0,
        CLS_FLOAT  = 4'd1,
        CLS_STRING = 4'd2,
        CLS_ATOM   = 4'd3,
        CLS_EMPTY  = 4'd4,
        CLS_LPAREN = 4'd5,
        CLS_RPAREN = 4'd6,
        CLS_PLAN   = 4'd7,
        CLS_AT     = 4'd8
    } token_class_t;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LESS      = 8'h3C;
    localparam logic [7:0] CH_GREATER   = 8'h3E;
    localparam logic [7:0] CH_AT        = 8'h40;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // Queue between the scanner and the output stage; a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Everything one input byte produces: an optional finished token and an
    // optional one-byte token or end marker that follows it.
    typedef struct packed {
        logic         tok_valid;
        token_class_t tok_class;
        logic [15:0]  tok_start;
        logic [15:0]  tok_length;
        logic         tok_neg;
        logic [63:0]  tok_mag;
        logic         sec_valid;
        logic         sec_end;
        token_class_t sec_class;
        logic [15:0]  sec_start;
    } entry_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

/* rtl/sexpr_token_scanner_classifier.sv */
// S-expression token scanner and classifier, top level.
// Depends on sts_pkg, sts_front, sts_queue and sts_back.
//
// The byte channel (byte_valid, byte_stall, ch) takes one string byte per
// transaction; a zero byte ends the string. The token channel (token_valid,
// token_stall and the result fields) delivers one result per transaction:
// a token with its class, start offset, raw length and integer value, or the
// end-of-string marker. last_of_run marks the final result a byte caused.
// A byte causes zero, one or two results.
//
// A byte's results reach the token channel through the queue and the output
// register. The scanner takes a byte every cycle while the queue is not full;
// each byte's token update is a compare and a multiply-by-ten accumulate. The
// output register delivers one result per cycle while the receiver does not
// stall, so bytes that close a token and are a bracket or the string's end give
// two results. A four-entry queue separates scanner and output stage; when the
// receiver stalls, results hold steady in the output register and byte_stall
// rises once the queue is full. Reset clears the queue, the output register and
// the scanner state, which then starts at offset zero with no open token.
module sexpr_token_scanner_classifier #(
    parameter longint unsigned MAX_STRING_BYTES = 65536,
    parameter int              INT_BITS         = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  ch,
    output logic        token_valid,
    input  logic        token_stall,
    output logic        is_end,
    output logic [3:0]  token_class,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic [63:0] int_value,
    output logic        last_of_run
);
    import sts_pkg::*;

    entry_t push_entry;
    entry_t head;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;

    sts_front #(
        .MAX_STRING_BYTES (MAX_STRING_BYTES),
        .INT_BITS         (INT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .ch         (ch),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    sts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    sts_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (q_empty),
        .pop          (pop),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .is_end       (is_end),
        .token_class  (token_class),
        .token_start  (token_start),
        .token_length (token_length),
        .int_value    (int_value),
        .last_of_run  (last_of_run)
    );

endmodule

/* rtl/sts_front.sv */
// Scanner front end: takes one byte per transaction, tracks the pending token
// and classifies it. Depends on sts_pkg; feeds entries to sts_queue.
module sts_front #(
    parameter longint unsigned MAX_STRING_BYTES = 65536,
    parameter int              INT_BITS         = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    output logic            byte_stall,
    input  logic [7:0]      ch,
    input  logic            q_full,
    output logic            push,
    output sts_pkg::entry_t push_entry
);
    import sts_pkg::*;

    localparam longint unsigned CAP_WIDE = MAX_STRING_BYTES - 64'd1;
    localparam logic [15:0] POS_CAP = (CAP_WIDE > 64'd65535) ? 16'hFFFF : 16'(CAP_WIDE);
    localparam logic [INT_BITS-1:0] LIM = {1'b1, {(INT_BITS-1){1'b0}}};

    logic [15:0]         position_reg, position_next;
    logic                in_token_reg, in_token_next;
    logic                escape_reg, escape_next;
    logic [15:0]         start_reg, start_next;
    logic [15:0]         raw_len_reg, raw_len_next;
    logic [23:0]         lead_reg, lead_next;
    logic [7:0]          final_reg, final_next;
    logic                digits_reg, digits_next;
    logic                neg_reg, neg_next;
    logic [INT_BITS-1:0] mag_reg, mag_next;
    logic                ovf_reg, ovf_next;

    logic                accept;
    logic                is_nul, is_ws, is_punct, tok_emit;
    logic [7:0]          b0, b1, b2, p0, p1;
    logic [15:0]         nlen;
    logic                is_num, fits, is_int;
    token_class_t        tok_class, punct_class;
    logic [INT_BITS+3:0] mag_x, acc;
    logic [3:0]          digit;

    assign byte_stall = q_full;
    assign accept     = byte_valid && !q_full;

    // Classification of the pending token from its stored summary.
    always_comb
    begin
        b0   = lead_reg[7:0];
        b1   = lead_reg[15:8];
        b2   = lead_reg[23:16];
        p0   = b0;
        p1   = b1;
        nlen = raw_len_reg;
        if ((b0 == CH_PLUS) || (b0 == CH_MINUS))
        begin
            p0   = b1;
            p1   = b2;
            nlen = raw_len_reg - 16'd1;
        end
        is_num = ((nlen > 16'd0) && is_digit(p0)) ||
                 ((nlen > 16'd1) && (p0 == CH_DOT) && is_digit(p1));
        fits   = !ovf_reg && (neg_reg ? (mag_reg <= LIM) : (mag_reg < LIM));
        is_int = 1'b0;
        if ((raw_len_reg == 16'd2) && (b0 == CH_LESS) && (b1 == CH_GREATER))
            tok_class = CLS_EMPTY;
        else if (is_num)
        begin
            is_int    = digits_reg && is_digit(p0) && fits;
            tok_class = is_int ? CLS_INT : CLS_FLOAT;
        end
        else if ((b0 == CH_AT) && (raw_len_reg == 16'd1))
            tok_class = CLS_AT;
        else if ((b0 == CH_QUOTE) && (raw_len_reg > 16'd1) && (final_reg == CH_QUOTE))
            tok_class = CLS_STRING;
        else
            tok_class = CLS_ATOM;
    end

    always_comb
    begin
        unique case (ch)
            CH_LPAREN: punct_class = CLS_LPAREN;
            CH_RPAREN: punct_class = CLS_RPAREN;
            CH_LBRACE: punct_class = CLS_PLAN;
            default:   punct_class = CLS_ATOM;
        endcase
    end

    always_comb
    begin
        is_nul   = (ch == CH_NUL);
        is_ws    = !escape_reg && ((ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NEWLINE));
        is_punct = !escape_reg && ((ch == CH_LPAREN) || (ch == CH_RPAREN) ||
                                   (ch == CH_LBRACE) || (ch == CH_RBRACE));
        tok_emit = in_token_reg && (is_nul || is_ws || is_punct);
        push     = accept && (tok_emit || is_nul || is_punct);

        push_entry.tok_valid  = tok_emit;
        push_entry.tok_class  = tok_class;
        push_entry.tok_start  = start_reg;
        push_entry.tok_length = (tok_class == CLS_EMPTY) ? 16'd0 : raw_len_reg;
        push_entry.tok_neg    = neg_reg;
        push_entry.tok_mag    = is_int ? 64'(mag_reg) : 64'd0;
        push_entry.sec_valid  = is_nul || is_punct;
        push_entry.sec_end    = is_nul;
        push_entry.sec_class  = is_nul ? CLS_INT : punct_class;
        push_entry.sec_start  = is_nul ? 16'd0 : position_reg;
    end

    // Next state. A token that is not open is always held in its cleared
    // form, so appending works from the registers directly.
    always_comb
    begin
        digit = ch[3:0];
        mag_x = {4'b0000, mag_reg};
        acc   = (mag_x << 3) + (mag_x << 1) + {{INT_BITS{1'b0}}, digit};

        position_next = (position_reg < POS_CAP) ? position_reg + 16'd1 : position_reg;
        in_token_next = in_token_reg;
        escape_next   = escape_reg;
        start_next    = start_reg;
        raw_len_next  = raw_len_reg;
        lead_next     = lead_reg;
        final_next    = final_reg;
        digits_next   = digits_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        ovf_next      = ovf_reg;

        if (is_nul || is_ws || is_punct)
        begin
            if (is_nul)
                position_next = 16'd0;
            in_token_next = 1'b0;
            escape_next   = 1'b0;
            start_next    = 16'd0;
            raw_len_next  = 16'd0;
            lead_next     = 24'd0;
            final_next    = 8'd0;
            digits_next   = 1'b1;
            neg_next      = 1'b0;
            mag_next      = '0;
            ovf_next      = 1'b0;
        end
        else
        begin
            in_token_next = 1'b1;
            if (!in_token_reg)
                start_next = position_reg;
            case (raw_len_reg)
                16'd0:   lead_next[7:0]   = ch;
                16'd1:   lead_next[15:8]  = ch;
                16'd2:   lead_next[23:16] = ch;
                default: lead_next        = lead_reg;
            endcase
            final_next = ch;
            if ((raw_len_reg == 16'd0) && ((ch == CH_PLUS) || (ch == CH_MINUS)))
                neg_next = (ch == CH_MINUS);
            else if (digits_reg && is_digit(ch))
            begin
                if (!ovf_reg)
                begin
                    if (acc > {4'b0000, LIM})
                        ovf_next = 1'b1;
                    else
                        mag_next = acc[INT_BITS-1:0];
                end
            end
            else
                digits_next = 1'b0;
            if (raw_len_reg < LEN_MAX)
                raw_len_next = raw_len_reg + 16'd1;
            escape_next = escape_reg ? 1'b0 : (ch == CH_BACKSLASH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= 16'd0;
            in_token_reg <= 1'b0;
            escape_reg   <= 1'b0;
            start_reg    <= 16'd0;
            raw_len_reg  <= 16'd0;
            lead_reg     <= 24'd0;
            final_reg    <= 8'd0;
            digits_reg   <= 1'b1;
            neg_reg      <= 1'b0;
            mag_reg      <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (accept)
        begin
            position_reg <= position_next;
            in_token_reg <= in_token_next;
            escape_reg   <= escape_next;
            start_reg    <= start_next;
            raw_len_reg  <= raw_len_next;
            lead_reg     <= lead_next;
            final_reg    <= final_next;
            digits_reg   <= digits_next;
            neg_reg      <= neg_next;
            mag_reg      <= mag_next;
            ovf_reg      <= ovf_next;
        end
    end

endmodule

/* rtl/sts_queue.sv */
// Small FIFO of scanner entries between the front end and the output stage.
// Depends on sts_pkg for the entry type and the depth.
module sts_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sts_pkg::entry_t push_entry,
    input  logic            pop,
    output sts_pkg::entry_t head,
    output logic            full,
    output logic            empty
);
    import sts_pkg::*;

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign head  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |=> !(push && $past(push)) || (count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH)))
        else $error("queue count passed its depth");
`endif
`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");
`endif

endmodule

/* rtl/sts_back.sv */
// Output stage: pops queue entries and presents their results one per
// transaction from an output register. Depends on sts_pkg.
module sts_back (
    input  logic            clk,
    input  logic            rst_n,
    input  sts_pkg::entry_t head,
    input  logic            empty,
    output logic            pop,
    output logic            token_valid,
    input  logic            token_stall,
    output logic            is_end,
    output logic [3:0]      token_class,
    output logic [15:0]     token_start,
    output logic [15:0]     token_length,
    output logic [63:0]     int_value,
    output logic            last_of_run
);
    import sts_pkg::*;

    logic         out_valid_reg;
    logic         pend_reg;
    logic         pend_end_reg;
    token_class_t pend_class_reg;
    logic [15:0]  pend_start_reg;
    logic         is_end_reg;
    token_class_t class_reg;
    logic [15:0]  start_reg;
    logic [15:0]  length_reg;
    logic [63:0]  value_reg;
    logic         last_reg;
    logic         load;

    assign load = !out_valid_reg || !token_stall;
    assign pop  = load && !pend_reg && !empty;

    assign token_valid  = out_valid_reg;
    assign is_end       = is_end_reg;
    assign token_class  = class_reg;
    assign token_start  = start_reg;
    assign token_length = length_reg;
    assign int_value    = value_reg;
    assign last_of_run  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
                pend_reg      <= 1'b0;
            end
            else if (!empty)
            begin
                out_valid_reg <= 1'b1;
                pend_reg      <= head.tok_valid && head.sec_valid;
            end
            else
                out_valid_reg <= 1'b0;
        end
    end

    // A one-byte token or end marker that follows a finished token waits
    // in the pending register for the next free output slot.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg)
            begin
                is_end_reg <= pend_end_reg;
                class_reg  <= pend_class_reg;
                start_reg  <= pend_start_reg;
                length_reg <= pend_end_reg ? 16'd0 : 16'd1;
                value_reg  <= 64'd0;
                last_reg   <= 1'b1;
            end
            else if (!empty)
            begin
                pend_end_reg   <= head.sec_end;
                pend_class_reg <= head.sec_class;
                pend_start_reg <= head.sec_start;
                if (head.tok_valid)
                begin
                    is_end_reg <= 1'b0;
                    class_reg  <= head.tok_class;
                    start_reg  <= head.tok_start;
                    length_reg <= head.tok_length;
                    value_reg  <= head.tok_neg ? 64'd0 - head.tok_mag : head.tok_mag;
                    last_reg   <= !head.sec_valid;
                end
                else
                begin
                    is_end_reg <= head.sec_end;
                    class_reg  <= head.sec_class;
                    start_reg  <= head.sec_start;
                    length_reg <= head.sec_end ? 16'd0 : 16'd1;
                    value_reg  <= 64'd0;
                    last_reg   <= 1'b1;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_pend_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> out_valid_reg && !last_reg)
        else $error("pending result without a first result in the output register");
`endif
`ifndef ASSERT_OFF
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && is_end_reg |-> last_reg && !pend_reg)
        else $error("end marker not the last result of its byte");
`endif

endmodule
